/* design/smbpec_pkg.sv */
// Shared types, constants and the CRC-8 step for the SMBus read PEC checker.
package smbpec_pkg;

    localparam int MAX_BLOCK = 32;
    localparam int RESULT_CAP = 32;
    localparam int CAP_LIMIT_I = (MAX_BLOCK < RESULT_CAP) ? MAX_BLOCK : RESULT_CAP;
    localparam int STORE_DEPTH = (CAP_LIMIT_I < 2) ? 2 : CAP_LIMIT_I;
    localparam int STORE_AW = $clog2(STORE_DEPTH);
    localparam logic [5:0] CAP_LIMIT = CAP_LIMIT_I[5:0];

    localparam logic [6:0] ADDR_RESET = 7'd11;
    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 7;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PEC_ENABLE = 1'b1;

    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_BYTE = 1'b1;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_PEC_ERR = 2'd2;

    typedef enum logic [1:0] {
        JOB_WORD,
        JOB_BLOCK,
        JOB_ERROR
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [1:0]  status;
        logic [15:0] word;
        logic [5:0]  blen;
    } t_job;

    typedef struct packed {
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } t_store_wr;

    typedef struct packed {
        logic q_full;
        logic drain_busy;
    } t_back_stat;

    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int b = 0; b < 8; b++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* design/smbus_read_pec_checker_top.sv */
// Word reads and errors pass from the byte that completes a transaction through the job queue
// and the output register; each block byte is read from the byte store, then registered out.
// Throughput: one byte transaction per cycle while not stalled; a begin transaction stalls input
// while the PEC is seeded. Block data bytes wait while the result stage or job queue is busy.
// Reset is synchronous and active low; it clears control state and restores the register
// defaults (address 11, PEC off); the byte store is not cleared.
module smbus_read_pec_checker_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [smbpec_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [smbpec_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_command,
    input  logic [7:0]                          i_register_code,
    input  logic                                i_block_mode,
    input  logic [5:0]                          i_block_capacity,
    input  logic [7:0]                          i_rx_byte,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_status,
    output logic [15:0]                         o_word_value,
    output logic [7:0]                          o_block_byte,
    output logic [4:0]                          o_byte_index,
    output logic [5:0]                          o_block_length,
    output logic                                o_last
);
    import smbpec_pkg::*;

    t_back_stat back_stat;
    t_store_wr  store_wr;
    t_job       push_job;
    t_job       head_job;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    logic       back_busy;

    assign back_stat.q_full = q_full;
    assign back_stat.drain_busy = back_busy || !q_empty;

    smbpec_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_register_code  (i_register_code),
        .i_block_mode     (i_block_mode),
        .i_block_capacity (i_block_capacity),
        .i_rx_byte        (i_rx_byte),
        .i_back_stat      (back_stat),
        .o_push           (push),
        .o_job            (push_job),
        .o_store_wr       (store_wr)
    );

    smbpec_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    smbpec_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_store_wr     (store_wr),
        .i_job          (head_job),
        .i_q_empty      (q_empty),
        .o_pop          (pop),
        .o_busy         (back_busy),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_word_value   (o_word_value),
        .o_block_byte   (o_block_byte),
        .o_byte_index   (o_byte_index),
        .o_block_length (o_block_length),
        .o_last         (o_last)
    );

endmodule

/* design/smbpec_front.sv */
// Front end: accepts transactions, tracks the read phase, runs the PEC and issues jobs.
module smbpec_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [smbpec_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [smbpec_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic                   i_command,
    input  logic [7:0]             i_register_code,
    input  logic                   i_block_mode,
    input  logic [5:0]             i_block_capacity,
    input  logic [7:0]             i_rx_byte,
    input  smbpec_pkg::t_back_stat i_back_stat,
    output logic                   o_push,
    output smbpec_pkg::t_job       o_job,
    output smbpec_pkg::t_store_wr  o_store_wr
);
    import smbpec_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_DATA,
        PH_PEC
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [6:0]  r_dev_addr;
    logic        r_pec_en;
    logic [7:0]  r_hdr_crc;
    logic        r_seed_pend;
    logic [7:0]  r_crc, n_crc;
    logic        r_is_block;
    logic [5:0]  r_cap;
    logic [5:0]  r_exp_len, n_exp_len;
    logic [5:0]  r_seen, n_seen;
    logic [15:0] r_word, n_word;
    logic        accept;
    logic        hazard;
    logic [7:0]  crc_rx;
    logic [5:0]  seen_inc;

    assign hazard = (r_phase == PH_DATA) && r_is_block && i_back_stat.drain_busy;
    assign o_in_stall = r_seed_pend || i_back_stat.q_full || hazard;
    assign accept = i_in_valid && !o_in_stall;
    assign crc_rx = crc8_feed(r_crc, i_rx_byte);
    assign seen_inc = r_seen + 6'd1;

    assign o_store_wr.we = accept && (i_command == CMD_BYTE) && (r_phase == PH_DATA)
                           && r_is_block;
    assign o_store_wr.addr = r_seen[STORE_AW-1:0];
    assign o_store_wr.data = i_rx_byte;

    always_comb begin
        n_phase = r_phase;
        n_crc = r_crc;
        n_exp_len = r_exp_len;
        n_seen = r_seen;
        n_word = r_word;
        o_push = 1'b0;
        o_job.kind = JOB_WORD;
        o_job.status = ST_OK;
        o_job.word = 16'd0;
        o_job.blen = 6'd0;
        if (accept && i_command == CMD_BYTE) begin
            case (r_phase)
                PH_LEN: begin
                    n_crc = crc_rx;
                    if (i_rx_byte == 8'd0 || i_rx_byte > {2'b00, r_cap}) begin
                        n_phase = PH_IDLE;
                        o_push = 1'b1;
                        o_job.kind = JOB_ERROR;
                        o_job.status = ST_BAD_LEN;
                    end else begin
                        n_exp_len = i_rx_byte[5:0];
                        n_seen = 6'd0;
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_crc = crc_rx;
                    n_seen = seen_inc;
                    n_word = {i_rx_byte, r_word[15:8]};
                    if (seen_inc >= r_exp_len) begin
                        if (r_pec_en) begin
                            n_phase = PH_PEC;
                        end else begin
                            n_phase = PH_IDLE;
                            o_push = 1'b1;
                            o_job.kind = r_is_block ? JOB_BLOCK : JOB_WORD;
                            o_job.word = r_is_block ? 16'd0 : n_word;
                            o_job.blen = r_is_block ? r_exp_len : 6'd0;
                        end
                    end
                end
                PH_PEC: begin
                    n_phase = PH_IDLE;
                    o_push = 1'b1;
                    if (i_rx_byte != r_crc) begin
                        o_job.kind = JOB_ERROR;
                        o_job.status = ST_PEC_ERR;
                        o_job.blen = r_is_block ? r_exp_len : 6'd0;
                    end else begin
                        o_job.kind = r_is_block ? JOB_BLOCK : JOB_WORD;
                        o_job.word = r_is_block ? 16'd0 : r_word;
                        o_job.blen = r_is_block ? r_exp_len : 6'd0;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_dev_addr <= ADDR_RESET;
            r_pec_en <= 1'b0;
            r_hdr_crc <= crc8_feed(8'h00, {ADDR_RESET, 1'b0});
            r_seed_pend <= 1'b0;
            r_crc <= 8'h00;
            r_is_block <= 1'b0;
            r_cap <= 6'd0;
            r_exp_len <= 6'd0;
            r_seen <= 6'd0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DEVICE_ADDRESS: begin
                        r_dev_addr <= i_cfg_wdata;
                        r_hdr_crc <= crc8_feed(8'h00, {i_cfg_wdata, 1'b0});
                    end
                    CFG_PEC_ENABLE: begin
                        r_pec_en <= i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (r_seed_pend) begin
                r_crc <= crc8_feed(r_crc, {r_dev_addr, 1'b1});
                r_seed_pend <= 1'b0;
            end else if (accept && i_command == CMD_BEGIN) begin
                r_crc <= crc8_feed(r_hdr_crc, i_register_code);
                r_seed_pend <= 1'b1;
                r_cap <= (i_block_capacity > CAP_LIMIT) ? CAP_LIMIT : i_block_capacity;
                r_is_block <= i_block_mode;
                r_seen <= 6'd0;
                r_exp_len <= i_block_mode ? 6'd0 : 6'd2;
                r_phase <= i_block_mode ? PH_LEN : PH_DATA;
            end else begin
                r_phase <= n_phase;
                r_crc <= n_crc;
                r_exp_len <= n_exp_len;
                r_seen <= n_seen;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

endmodule

/* design/smbpec_queue.sv */
// Two-entry job queue between the front end and the result stage.
module smbpec_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  smbpec_pkg::t_job i_job,
    input  logic             i_pop,
    output smbpec_pkg::t_job o_job,
    output logic             o_empty,
    output logic             o_full
);
    import smbpec_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full = (r_cnt == 2'd2);
    assign o_job = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("Job queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("Job queue read while empty.");

endmodule

/* design/smbpec_back.sv */
// Result stage: drains jobs, holds the byte store and drives the output register.
module smbpec_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  smbpec_pkg::t_store_wr i_store_wr,
    input  smbpec_pkg::t_job      i_job,
    input  logic                  i_q_empty,
    output logic                  o_pop,
    output logic                  o_busy,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [1:0]            o_status,
    output logic [15:0]           o_word_value,
    output logic [7:0]            o_block_byte,
    output logic [4:0]            o_byte_index,
    output logic [5:0]            o_block_length,
    output logic                  o_last
);
    import smbpec_pkg::*;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_READ,
        BS_SEND
    } t_bstate;

    t_bstate    r_state;
    logic [7:0] r_store [STORE_DEPTH];
    logic [7:0] r_rd_data;
    logic [4:0] r_idx;
    logic [5:0] r_blen;
    logic       out_free;
    logic       idx_last;

    assign out_free = !o_out_valid || !i_out_stall;
    assign o_pop = (r_state == BS_IDLE) && !i_q_empty && ((i_job.kind == JOB_BLOCK) || out_free);
    assign o_busy = (r_state != BS_IDLE);
    assign idx_last = (({1'b0, r_idx} + 6'd1) == r_blen);

    always_ff @(posedge i_clk) begin
        if (i_store_wr.we) begin
            r_store[i_store_wr.addr] <= i_store_wr.data;
        end
        r_rd_data <= r_store[r_idx[STORE_AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_IDLE;
            o_out_valid <= 1'b0;
            r_idx <= 5'd0;
            r_blen <= 6'd0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                BS_IDLE: begin
                    if (o_pop) begin
                        if (i_job.kind == JOB_BLOCK) begin
                            r_idx <= 5'd0;
                            r_blen <= i_job.blen;
                            r_state <= BS_READ;
                        end else begin
                            o_out_valid <= 1'b1;
                            o_status <= i_job.status;
                            o_word_value <= i_job.word;
                            o_block_byte <= 8'd0;
                            o_byte_index <= 5'd0;
                            o_block_length <= i_job.blen;
                            o_last <= 1'b1;
                        end
                    end
                end
                BS_READ: begin
                    r_state <= BS_SEND;
                end
                BS_SEND: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        o_status <= ST_OK;
                        o_word_value <= 16'd0;
                        o_block_byte <= r_rd_data;
                        o_byte_index <= r_idx;
                        o_block_length <= r_blen;
                        o_last <= idx_last;
                        if (idx_last) begin
                            r_state <= BS_IDLE;
                        end else begin
                            r_idx <= r_idx + 5'd1;
                            r_state <= BS_READ;
                        end
                    end
                end
                default: begin
                    r_state <= BS_IDLE;
                end
            endcase
        end
    end

    a_idx_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_SEND) |-> ({1'b0, r_idx} < r_blen))
        else $error("Block byte index runs past the block length.");

    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_store_wr.we |-> (r_state == BS_IDLE))
        else $error("Byte store written while a block is being sent.");

endmodule

/* tb/tb_smbus_read_pec_checker_top.sv */
// Self-checking testbench for the SMBus read PEC checker with directed and random reads.
module tb_smbus_read_pec_checker_top;
    import smbpec_pkg::*;

    localparam logic MODE_WORD = 1'b0;
    localparam logic MODE_BLOCK = 1'b1;
    localparam int QUIET_CYCLES = 8;

    typedef enum logic [1:0] {
        RD_IDLE,
        RD_LEN,
        RD_DATA,
        RD_PEC
    } t_rd_phase;

    typedef struct packed {
        logic       command;
        logic [7:0] register_code;
        logic       block_mode;
        logic [5:0] block_capacity;
        logic [7:0] rx_byte;
    } t_rd_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] word_value;
        logic [7:0]  block_byte;
        logic [4:0]  byte_index;
        logic [5:0]  block_length;
        logic        last;
    } t_rd_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_command = 1'b0;
    logic [7:0]            i_register_code = '0;
    logic                  i_block_mode = 1'b0;
    logic [5:0]            i_block_capacity = '0;
    logic [7:0]            i_rx_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [1:0]            o_status;
    logic [15:0]           o_word_value;
    logic [7:0]            o_block_byte;
    logic [4:0]            o_byte_index;
    logic [5:0]            o_block_length;
    logic                  o_last;

    logic [6:0] dev_addr;
    logic       pec_on;
    logic [7:0] pec_crc;
    t_rd_phase  rd_phase;
    logic       rd_block;
    logic [5:0] cap_limit;
    logic [5:0] blk_len;
    logic [5:0] seen_count;
    logic [7:0] rx_store [0:STORE_DEPTH-1];

    t_rd_result awaited_results[$];
    int         mismatches = 0;
    int         counted_items = 0;
    bit         no_gaps = 1'b0;
    int         out_hold = 0;

    smbus_read_pec_checker_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_command        (i_command),
        .i_register_code  (i_register_code),
        .i_block_mode     (i_block_mode),
        .i_block_capacity (i_block_capacity),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_word_value     (o_word_value),
        .o_block_byte     (o_block_byte),
        .o_byte_index     (o_byte_index),
        .o_block_length   (o_block_length),
        .o_last           (o_last)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [7:0] pec_crc8(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

    function automatic void queue_read_result(input logic [1:0] st, input logic [15:0] w,
                                              input logic [7:0] b, input logic [4:0] idx,
                                              input logic [5:0] len, input logic lst);
        awaited_results.push_back('{st, w, b, idx, len, lst});
    endfunction

    function automatic void complete_read();
        rd_phase = RD_IDLE;
        if (!rd_block) begin
            queue_read_result(ST_OK, {rx_store[1], rx_store[0]}, 8'h00, 5'd0, 6'd0, 1'b1);
        end else begin
            for (int i = 0; i < blk_len; i++) begin
                queue_read_result(ST_OK, 16'h0000, rx_store[i], i[4:0], blk_len,
                                  (i + 1 == blk_len));
            end
        end
    endfunction

    function automatic void advance_reader(input t_rd_item it);
        logic [7:0] hdr;
        if (it.command == CMD_BEGIN) begin
            hdr = {dev_addr, 1'b0};
            pec_crc = pec_crc8(pec_crc8(pec_crc8(8'h00, hdr), it.register_code), hdr | 8'h01);
            cap_limit = (it.block_capacity > CAP_LIMIT) ? CAP_LIMIT : it.block_capacity;
            rd_block = it.block_mode;
            seen_count = 6'd0;
            blk_len = it.block_mode ? 6'd0 : 6'd2;
            rd_phase = it.block_mode ? RD_LEN : RD_DATA;
            counted_items++;
        end else begin
            if (rd_phase != RD_IDLE) begin
                counted_items++;
            end
            case (rd_phase)
                RD_LEN: begin
                    pec_crc = pec_crc8(pec_crc, it.rx_byte);
                    if (it.rx_byte == 8'd0 || it.rx_byte > cap_limit) begin
                        rd_phase = RD_IDLE;
                        queue_read_result(ST_BAD_LEN, 16'h0000, 8'h00, 5'd0, 6'd0, 1'b1);
                    end else begin
                        blk_len = it.rx_byte[5:0];
                        seen_count = 6'd0;
                        rd_phase = RD_DATA;
                    end
                end
                RD_DATA: begin
                    pec_crc = pec_crc8(pec_crc, it.rx_byte);
                    if (seen_count < STORE_DEPTH) begin
                        rx_store[seen_count[STORE_AW-1:0]] = it.rx_byte;
                    end
                    seen_count = seen_count + 6'd1;
                    if (seen_count >= blk_len) begin
                        if (pec_on) begin
                            rd_phase = RD_PEC;
                        end else begin
                            complete_read();
                        end
                    end
                end
                RD_PEC: begin
                    if (it.rx_byte != pec_crc) begin
                        rd_phase = RD_IDLE;
                        queue_read_result(ST_PEC_ERR, 16'h0000, 8'h00, 5'd0,
                                          rd_block ? blk_len : 6'd0, 1'b1);
                    end else begin
                        complete_read();
                    end
                end
                default: begin
                end
            endcase
        end
    endfunction

    function automatic void flag_result(input string what, input t_rd_result want,
                                        input t_rd_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected st=%0d word=%h byte=%h idx=%0d len=%0d last=%0d",
                     what, want.status, want.word_value, want.block_byte, want.byte_index,
                     want.block_length, want.last);
            $display("    got st=%0d word=%h byte=%h idx=%0d len=%0d last=%0d",
                     got.status, got.word_value, got.block_byte, got.byte_index,
                     got.block_length, got.last);
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_rd_result got;
        t_rd_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_status, o_word_value, o_block_byte, o_byte_index, o_block_length, o_last};
            if (awaited_results.size() == 0) begin
                flag_result("unexpected result", '0, got);
            end else begin
                want = awaited_results.pop_front();
                if (got !== want) begin
                    flag_result("result mismatch", want, got);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) begin
            out_hold = no_gaps ? 0 : $urandom_range(0, 8);
        end else if (out_hold != 0) begin
            out_hold = out_hold - 1;
        end
        i_out_stall <= (out_hold != 0);
    end

    task automatic send_item(input t_rd_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= it.command;
        i_register_code <= it.register_code;
        i_block_mode <= it.block_mode;
        i_block_capacity <= it.block_capacity;
        i_rx_byte <= it.rx_byte;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        advance_reader(it);
    endtask

    task automatic send_begin(input logic mode, input logic [7:0] rc, input logic [5:0] cap);
        t_rd_item it;
        it.command = CMD_BEGIN;
        it.register_code = rc;
        it.block_mode = mode;
        it.block_capacity = cap;
        it.rx_byte = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_rd_item it;
        it.command = CMD_BYTE;
        it.register_code = 8'($urandom);
        it.block_mode = 1'($urandom);
        it.block_capacity = 6'($urandom);
        it.rx_byte = b;
        send_item(it);
    endtask

    task automatic send_pec(input bit good);
        send_byte(good ? pec_crc : pec_crc ^ (8'h01 << $urandom_range(0, 7)));
    endtask

    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == CFG_DEVICE_ADDRESS) begin
            dev_addr = val;
        end else begin
            pec_on = val[0];
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_pec(input logic on);
        logic [CFG_DATA_W-2:0] junk;
        junk = (CFG_DATA_W - 1)'($urandom);
        write_reg(CFG_PEC_ENABLE, {junk, on});
    endtask

    task automatic test_word_read();
        send_begin(MODE_WORD, 8'h00, 6'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_block_read();
        send_begin(MODE_BLOCK, 8'h5A, 6'd2);
        send_byte(8'd2);
        send_byte(8'hFF);
        send_byte(8'h00);
    endtask

    task automatic test_bad_length();
        send_begin(MODE_BLOCK, 8'h81, 6'd5);
        send_byte(8'd0);
        send_begin(MODE_BLOCK, 8'h42, 6'd0);
        send_byte(8'd1);
        send_begin(MODE_BLOCK, 8'h24, 6'd63);
        send_byte(8'd33);
    endtask

    task automatic test_idle_and_restart();
        wait_quiet();
        send_byte(8'hA5);
        send_begin(MODE_BLOCK, 8'hC3, 6'd4);
        send_byte(8'd3);
        send_begin(MODE_WORD, 8'h12, 6'd32);
        send_byte(8'h34);
        send_byte(8'h56);
    endtask

    task automatic test_pec_check();
        wait_quiet();
        write_reg(CFG_DEVICE_ADDRESS, 7'd127);
        set_pec(1'b1);
        send_begin(MODE_BLOCK, 8'hFF, 6'd32);
        send_byte(8'd1);
        send_byte(8'h80);
        send_pec(1'b0);
    endtask

    task automatic test_midread_config();
        wait_quiet();
        set_pec(1'b0);
        send_begin(MODE_WORD, 8'h0F, 6'd0);
        wait_quiet();
        write_reg(CFG_DEVICE_ADDRESS, 7'h2A);
        set_pec(1'b1);
        send_byte(8'hC0);
        send_byte(8'h01);
        send_pec(1'b1);
    endtask

    task automatic run_random_reads(input int count);
        int         stop_at;
        int         pick;
        int         len;
        int         eff;
        bit         big;
        logic [5:0] cap;
        stop_at = counted_items + count;
        while (counted_items < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                send_begin(MODE_WORD, 8'($urandom), 6'($urandom));
                send_byte(8'($urandom));
                send_byte(8'($urandom));
                if (pec_on) begin
                    send_pec($urandom_range(0, 4) != 0);
                end
            end else if (pick < 85) begin
                big = ($urandom_range(0, 19) == 0);
                cap = big ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 8));
                eff = int'((cap > CAP_LIMIT) ? CAP_LIMIT : cap);
                send_begin(MODE_BLOCK, 8'($urandom), cap);
                case ($urandom_range(0, 11))
                    0: len = 0;
                    1: len = $urandom_range(eff + 1, 255);
                    2, 3: len = eff;
                    default: len = (eff == 0) ? 0 : $urandom_range(1, eff);
                endcase
                send_byte(len[7:0]);
                if (len != 0 && len <= eff) begin
                    repeat (len) send_byte(8'($urandom));
                    if (pec_on) begin
                        send_pec($urandom_range(0, 4) != 0);
                    end
                end
            end else begin
                case ($urandom_range(0, 2))
                    0: send_byte(8'($urandom));
                    1: begin
                        send_begin(1'($urandom), 8'($urandom), 6'($urandom));
                        repeat ($urandom_range(0, 2)) send_byte(8'($urandom));
                    end
                    default: begin
                        send_begin(MODE_WORD, 8'($urandom), 6'($urandom));
                        send_byte(8'($urandom));
                    end
                endcase
            end
        end
    endtask

    task automatic test_random_reads();
        for (int p = 0; p < 6; p++) begin
            wait_quiet();
            case (p)
                0: write_reg(CFG_DEVICE_ADDRESS, 7'd0);
                1: write_reg(CFG_DEVICE_ADDRESS, 7'd127);
                4: write_reg(CFG_DEVICE_ADDRESS, ADDR_RESET);
                default: write_reg(CFG_DEVICE_ADDRESS, 7'($urandom));
            endcase
            set_pec((p == 0 || p == 3) ? 1'b0 : (p == 5) ? 1'($urandom) : 1'b1);
            no_gaps = (p == 2);
            run_random_reads(65);
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        dev_addr = ADDR_RESET;
        pec_on = 1'b0;
        pec_crc = 8'h00;
        rd_phase = RD_IDLE;
        rd_block = 1'b0;
        cap_limit = 6'd0;
        blk_len = 6'd0;
        seen_count = 6'd0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_word_read();
        test_block_read();
        test_bad_length();
        test_idle_and_restart();
        test_pec_check();
        test_midread_config();
        test_random_reads();
        wait_quiet();
        if (mismatches == 0 && awaited_results.size() == 0) begin
            $display("tb_smbus_read_pec_checker_top: PASS");
        end else begin
            $display("tb_smbus_read_pec_checker_top: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_smbus_read_pec_checker_top: FAIL");
        $finish;
    end

endmodule

/* smbus_read_pec_checker_top.f */
design/smbpec_pkg.sv
design/smbpec_front.sv
design/smbpec_queue.sv
design/smbpec_back.sv
design/smbus_read_pec_checker_top.sv
tb/tb_smbus_read_pec_checker_top.sv
